// ===== design/hmsct_pkg.sv =====
`timescale 1ns / 1ps

package hmsct_pkg;

    localparam logic [6:0] MAX_HOURS   = 7'd99;
    localparam logic [5:0] MAX_MINSEC  = 6'd59;
    localparam logic [9:0] MS_PER_SEC  = 10'd1000;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_SET   = 3'd1,
        MODE_RUN   = 3'd2,
        MODE_PAUSE = 3'd3,
        MODE_FIN   = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        FIELD_HOURS   = 2'd0,
        FIELD_MINUTES = 2'd1,
        FIELD_SECONDS = 2'd2
    } field_t;

    typedef enum logic [2:0] {
        BEEP_NONE   = 3'd0,
        BEEP_SHORT  = 3'd1,
        BEEP_DOUBLE = 3'd2,
        BEEP_ALARM  = 3'd3,
        BEEP_STOP   = 3'd4
    } beep_t;

    typedef enum logic [2:0] {
        EV_TICK      = 3'd0,
        EV_PRESS     = 3'd1,
        EV_LONG      = 3'd2,
        EV_SCROLL_UP = 3'd3,
        EV_SCROLL_DN = 3'd4
    } event_t;

    typedef enum logic [1:0] {
        CFG_BLINK = 2'd0,
        CFG_FLASH = 2'd1,
        CFG_ALARM = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [2:0] kind;
        logic       buzzer_busy;
    } evt_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [1:0] edit_field;
        logic [6:0] show_hours;
        logic [5:0] show_minutes;
        logic [5:0] show_seconds;
        logic       blink_on;
        logic       flash_on;
        logic       redraw;
        logic [2:0] beep;
    } res_t;

    typedef struct packed {
        logic [11:0] blink_period;
        logic [11:0] flash_period;
        logic [11:0] alarm_repeat;
    } cfg_t;

    // Remaining time is kept as whole seconds rounded up (rem_h:rem_m:rem_s)
    // plus rem_frac in 1..1000 ms within the last second (0 when expired).
    typedef struct packed {
        mode_t       mode;
        field_t      field;
        logic [6:0]  saved_h;
        logic [5:0]  saved_m;
        logic [5:0]  saved_s;
        logic [6:0]  edit_h;
        logic [5:0]  edit_m;
        logic [5:0]  edit_s;
        logic [6:0]  rem_h;
        logic [5:0]  rem_m;
        logic [5:0]  rem_s;
        logic [9:0]  rem_frac;
        logic        seen_valid;
        logic [5:0]  seen_sec;
        logic        dirty;
        logic        blink_phase;
        logic        flash_phase;
        logic        alarm_done;
        logic [11:0] blink_cnt;
        logic [11:0] flash_cnt;
        logic [11:0] alarm_cnt;
    } tmr_state_t;

    localparam cfg_t CFG_RESET = '{
        blink_period: 12'd500,
        flash_period: 12'd300,
        alarm_repeat: 12'd1500
    };

    localparam tmr_state_t STATE_RESET = '{
        mode:        MODE_IDLE,
        field:       FIELD_HOURS,
        saved_h:     7'd0,
        saved_m:     6'd5,
        saved_s:     6'd0,
        edit_h:      7'd0,
        edit_m:      6'd5,
        edit_s:      6'd0,
        rem_h:       7'd0,
        rem_m:       6'd0,
        rem_s:       6'd0,
        rem_frac:    10'd0,
        seen_valid:  1'b0,
        seen_sec:    6'd0,
        dirty:       1'b1,
        blink_phase: 1'b1,
        flash_phase: 1'b1,
        alarm_done:  1'b0,
        blink_cnt:   12'd0,
        flash_cnt:   12'd0,
        alarm_cnt:   12'd0
    };

endpackage

// ===== design/hmsct_next.sv =====
`timescale 1ns / 1ps

module hmsct_next
    import hmsct_pkg::*;
(
    input  tmr_state_t cur,
    input  cfg_t       cfg,
    input  evt_t       evt,
    output tmr_state_t nxt,
    output res_t       res
);

    function automatic logic [6:0] inc_wrap7(input logic [6:0] v, input logic [6:0] top);
        return (v >= top) ? 7'd0 : v + 7'd1;
    endfunction

    function automatic logic [6:0] dec_wrap7(input logic [6:0] v, input logic [6:0] top);
        return (v == 7'd0) ? top : v - 7'd1;
    endfunction

    function automatic logic [5:0] inc_wrap6(input logic [5:0] v, input logic [5:0] top);
        return (v >= top) ? 6'd0 : v + 6'd1;
    endfunction

    function automatic logic [5:0] dec_wrap6(input logic [5:0] v, input logic [5:0] top);
        return (v == 6'd0) ? top : v - 6'd1;
    endfunction

    tmr_state_t n;
    beep_t      beep;
    logic       entered;
    logic       rem_le_one;
    logic [11:0] el;

    assign rem_le_one = (cur.rem_h == 7'd0) && (cur.rem_m == 6'd0) &&
                        ((cur.rem_s == 6'd0) ||
                         ((cur.rem_s == 6'd1) && (cur.rem_frac <= 10'd1)));

    always_comb
    begin
        n       = cur;
        beep    = BEEP_NONE;
        entered = 1'b0;
        el      = 12'd0;

        case (evt.kind)
            EV_TICK:
            begin
                if (cur.mode == MODE_RUN)
                begin
                    if (rem_le_one)
                    begin
                        n.rem_h       = 7'd0;
                        n.rem_m       = 6'd0;
                        n.rem_s       = 6'd0;
                        n.rem_frac    = 10'd0;
                        n.mode        = MODE_FIN;
                        n.flash_cnt   = 12'd0;
                        n.flash_phase = 1'b1;
                        n.alarm_done  = 1'b0;
                        n.alarm_cnt   = 12'd0;
                        n.dirty       = 1'b1;
                        entered       = 1'b1;
                    end
                    else
                    begin
                        if (cur.rem_frac > 10'd1)
                        begin
                            n.rem_frac = cur.rem_frac - 10'd1;
                        end
                        else
                        begin
                            // borrow one whole second
                            n.rem_frac = MS_PER_SEC;
                            if (cur.rem_s != 6'd0)
                            begin
                                n.rem_s = cur.rem_s - 6'd1;
                            end
                            else
                            begin
                                n.rem_s = MAX_MINSEC;
                                if (cur.rem_m != 6'd0)
                                begin
                                    n.rem_m = cur.rem_m - 6'd1;
                                end
                                else
                                begin
                                    n.rem_m = MAX_MINSEC;
                                    n.rem_h = cur.rem_h - 7'd1;
                                end
                            end
                        end
                        if (!cur.seen_valid || (n.rem_s != cur.seen_sec))
                        begin
                            n.seen_valid = 1'b1;
                            n.seen_sec   = n.rem_s;
                            n.dirty      = 1'b1;
                        end
                    end
                end

                if (n.mode == MODE_FIN)
                begin
                    el = entered ? 12'd0 : n.flash_cnt + 12'd1;
                    if (el >= cfg.flash_period)
                    begin
                        n.flash_phase = ~n.flash_phase;
                        n.flash_cnt   = 12'd0;
                        n.dirty       = 1'b1;
                    end
                    else
                    begin
                        n.flash_cnt = el;
                    end

                    if (!n.alarm_done)
                    begin
                        beep         = BEEP_ALARM;
                        n.alarm_done = 1'b1;
                        n.alarm_cnt  = 12'd0;
                    end
                    else if (n.alarm_cnt + 12'd1 >= cfg.alarm_repeat)
                    begin
                        if (!evt.buzzer_busy)
                        begin
                            beep = BEEP_ALARM;
                        end
                        n.alarm_cnt = 12'd0;
                    end
                    else
                    begin
                        n.alarm_cnt = n.alarm_cnt + 12'd1;
                    end
                end

                if (cur.mode == MODE_SET)
                begin
                    if (cur.blink_cnt + 12'd1 >= cfg.blink_period)
                    begin
                        n.blink_phase = ~cur.blink_phase;
                        n.blink_cnt   = 12'd0;
                        n.dirty       = 1'b1;
                    end
                    else
                    begin
                        n.blink_cnt = cur.blink_cnt + 12'd1;
                    end
                end
            end

            EV_PRESS:
            begin
                case (cur.mode)
                    MODE_IDLE:
                    begin
                        n.mode        = MODE_SET;
                        n.field       = FIELD_HOURS;
                        n.edit_h      = cur.saved_h;
                        n.edit_m      = cur.saved_m;
                        n.edit_s      = cur.saved_s;
                        n.blink_phase = 1'b1;
                        n.blink_cnt   = 12'd0;
                        n.dirty       = 1'b1;
                    end
                    MODE_SET:
                    begin
                        if (cur.field == FIELD_HOURS || cur.field == FIELD_MINUTES)
                        begin
                            n.field       = (cur.field == FIELD_HOURS) ? FIELD_MINUTES
                                                                      : FIELD_SECONDS;
                            n.blink_phase = 1'b1;
                            n.blink_cnt   = 12'd0;
                            n.dirty       = 1'b1;
                        end
                        else if (cur.edit_h == 7'd0 && cur.edit_m == 6'd0 &&
                                 cur.edit_s == 6'd0)
                        begin
                            beep    = BEEP_DOUBLE;
                            n.field = FIELD_HOURS;
                            n.dirty = 1'b1;
                        end
                        else
                        begin
                            n.saved_h    = cur.edit_h;
                            n.saved_m    = cur.edit_m;
                            n.saved_s    = cur.edit_s;
                            n.rem_h      = cur.edit_h;
                            n.rem_m      = cur.edit_m;
                            n.rem_s      = cur.edit_s;
                            n.rem_frac   = MS_PER_SEC;
                            n.seen_valid = 1'b0;
                            n.mode       = MODE_RUN;
                            beep         = BEEP_SHORT;
                            n.dirty      = 1'b1;
                        end
                    end
                    MODE_RUN:
                    begin
                        n.mode  = MODE_PAUSE;
                        n.dirty = 1'b1;
                    end
                    MODE_PAUSE:
                    begin
                        n.mode  = MODE_RUN;
                        beep    = BEEP_SHORT;
                        n.dirty = 1'b1;
                    end
                    MODE_FIN:
                    begin
                        n.mode  = MODE_IDLE;
                        beep    = BEEP_STOP;
                        n.dirty = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end

            EV_LONG:
            begin
                if (cur.mode == MODE_PAUSE || cur.mode == MODE_RUN || cur.mode == MODE_SET)
                begin
                    n.mode     = MODE_IDLE;
                    n.rem_h    = 7'd0;
                    n.rem_m    = 6'd0;
                    n.rem_s    = 6'd0;
                    n.rem_frac = 10'd0;
                    n.dirty    = 1'b1;
                    beep       = BEEP_SHORT;
                end
            end

            EV_SCROLL_UP, EV_SCROLL_DN:
            begin
                if (cur.mode == MODE_SET)
                begin
                    case (cur.field)
                        FIELD_HOURS:
                            n.edit_h = (evt.kind == EV_SCROLL_UP)
                                     ? inc_wrap7(cur.edit_h, MAX_HOURS)
                                     : dec_wrap7(cur.edit_h, MAX_HOURS);
                        FIELD_MINUTES:
                            n.edit_m = (evt.kind == EV_SCROLL_UP)
                                     ? inc_wrap6(cur.edit_m, MAX_MINSEC)
                                     : dec_wrap6(cur.edit_m, MAX_MINSEC);
                        FIELD_SECONDS:
                            n.edit_s = (evt.kind == EV_SCROLL_UP)
                                     ? inc_wrap6(cur.edit_s, MAX_MINSEC)
                                     : dec_wrap6(cur.edit_s, MAX_MINSEC);
                        default:
                        begin
                        end
                    endcase
                    n.blink_phase = 1'b1;
                    n.blink_cnt   = 12'd0;
                    n.dirty       = 1'b1;
                end
            end

            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        res.mode       = n.mode;
        res.edit_field = n.field;
        case (n.mode)
            MODE_IDLE:
            begin
                res.show_hours   = n.saved_h;
                res.show_minutes = n.saved_m;
                res.show_seconds = n.saved_s;
            end
            MODE_SET:
            begin
                res.show_hours   = n.edit_h;
                res.show_minutes = n.edit_m;
                res.show_seconds = n.edit_s;
            end
            default:
            begin
                res.show_hours   = n.rem_h;
                res.show_minutes = n.rem_m;
                res.show_seconds = n.rem_s;
            end
        endcase
        res.blink_on = n.blink_phase;
        res.flash_on = n.flash_phase;
        res.redraw   = n.dirty;
        res.beep     = beep;

        // redraw is cleared once reported
        nxt       = n;
        nxt.dirty = 1'b0;
    end

endmodule

// ===== design/hms_countdown_timer_unit.sv =====
`timescale 1ns / 1ps

// Hours/minutes/seconds countdown timer. Each input item is one event (1 ms
// tick, press, long press, scroll up/down) and yields exactly one result item
// with mode, edit field, displayed time, blink/flash phases, a one-shot redraw
// flag and a buzzer command. Throughput is one item per clock unless stalled:
// the whole state update is a single pass of next-state logic, and the result
// is written to an output register on acceptance. That register frees the
// input side, so a new item is taken while the previous result drains; in_stall
// rises only when the output register is full and downstream stalls. Remaining
// time is held as h:m:s (rounded up) plus ms within the current second, so the
// display needs no divider. Configuration writes (periods in ms) are always
// ready and are meant to happen while the block is idle.
module hms_countdown_timer_unit
    import hmsct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  evt_t        in_item,

    output logic        out_valid,
    input  logic        out_stall,
    output res_t        out_item,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data
);

    tmr_state_t state_reg;
    tmr_state_t state_next;
    cfg_t       cfg_reg;
    res_t       res_next;
    res_t       out_reg;
    logic       out_valid_reg;
    logic       accept;

    // input is taken when the output register is empty or draining this cycle
    assign in_stall  = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    hmsct_next u_next (
        .cur (state_reg),
        .cfg (cfg_reg),
        .evt (in_item),
        .nxt (state_next),
        .res (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_BLINK: cfg_reg.blink_period <= cfg_data;
                CFG_FLASH: cfg_reg.flash_period <= cfg_data;
                CFG_ALARM: cfg_reg.alarm_repeat <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= STATE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import hmsct_pkg::*;

    // Event codes the block must ignore (kind field is 3 bits wide)
    localparam logic [2:0] EV_SPARE_LO = 3'd5;
    localparam logic [2:0] EV_SPARE_HI = 3'd7;
    // Register index with no register behind it
    localparam logic [1:0] CFG_SPARE   = 2'd3;

    localparam int LIMIT       = 1000000;  // cycles before declaring a hang
    localparam int PHASE_ITEMS = 30;       // minimum random items per config phase
    localparam int HOLD_CYCLES = 250;      // one long receiver hold-off

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    evt_t        in_item;
    logic        out_valid;
    logic        out_stall = 1'b0;
    res_t        out_item;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [11:0] cfg_data;

    hms_countdown_timer_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Timer model: config copy and state, advanced once per accepted item
    // ------------------------------------------------------------------
    logic [11:0] blink_per, flash_per, alarm_per;
    mode_t       t_mode;
    field_t      t_field;
    logic [6:0]  t_saved_h, t_edit_h;
    logic [5:0]  t_saved_m, t_saved_s, t_edit_m, t_edit_s;
    int unsigned t_rem;          // ms left in the run
    logic [7:0]  t_seen;         // last second shown, 255 = none yet
    logic        t_dirty, t_blink_ph, t_flash_ph, t_alarm_done;
    logic [11:0] t_blink_cnt, t_flash_cnt, t_alarm_cnt;

    res_t        due_displays[$];   // results owed by the block, oldest first
    int          errors = 0;
    int          items_sent;
    int          displays_seen = 0;
    int          cycles = 0;
    bit          send_steady;       // sender runs back to back when set
    bit          recv_steady = 1'b0; // receiver skips random stalls when set

    typedef struct packed {
        logic [2:0] kind;
        logic       busy;
        logic       known;   // want holds a hand-written result
        res_t       want;
    } step_row_t;

    step_row_t opening_steps[$];

    function automatic int unsigned roll(int unsigned v, int unsigned top, bit up);
        if (up)
            return (v >= top) ? 0 : v + 1;
        return (v == 0) ? top : v - 1;
    endfunction

    function void rearm_blink();
        t_blink_ph  = 1'b1;
        t_blink_cnt = '0;
        t_dirty     = 1'b1;
    endfunction

    function automatic res_t timer_next(evt_t ev);
        res_t        r;
        beep_t       bp;
        logic        entered;
        logic [11:0] el;
        int unsigned secs;
        int unsigned total;
        bit          up;
        bp      = BEEP_NONE;
        entered = 1'b0;
        up      = (ev.kind == EV_SCROLL_UP);
        case (ev.kind)
            EV_TICK:
            begin
                if (t_mode == MODE_RUN)
                begin
                    if (t_rem <= 1)
                    begin
                        t_rem        = 0;
                        t_mode       = MODE_FIN;
                        t_flash_cnt  = '0;
                        t_flash_ph   = 1'b1;
                        t_alarm_done = 1'b0;
                        t_alarm_cnt  = '0;
                        t_dirty      = 1'b1;
                        entered      = 1'b1;
                    end
                    else
                    begin
                        t_rem = t_rem - 1;
                        secs  = ((t_rem + 999) / 1000) % 60;
                        if (secs != t_seen)
                        begin
                            t_seen  = 8'(secs);
                            t_dirty = 1'b1;
                        end
                    end
                end
                if (t_mode == MODE_FIN)
                begin
                    // flash counter restarts on the expiry tick itself
                    el = entered ? 12'd0 : t_flash_cnt + 12'd1;
                    if (el >= flash_per)
                    begin
                        t_flash_ph  = ~t_flash_ph;
                        t_flash_cnt = '0;
                        t_dirty     = 1'b1;
                    end
                    else
                        t_flash_cnt = el;
                    if (!t_alarm_done)
                    begin
                        bp           = BEEP_ALARM;
                        t_alarm_done = 1'b1;
                        t_alarm_cnt  = '0;
                    end
                    else
                    begin
                        // repeat falls due: skipped if buzzer busy, timer restarts anyway
                        el = t_alarm_cnt + 12'd1;
                        if (el >= alarm_per)
                        begin
                            if (!ev.buzzer_busy)
                                bp = BEEP_ALARM;
                            t_alarm_cnt = '0;
                        end
                        else
                            t_alarm_cnt = el;
                    end
                end
                if (t_mode == MODE_SET)
                begin
                    el = t_blink_cnt + 12'd1;
                    if (el >= blink_per)
                    begin
                        t_blink_ph  = ~t_blink_ph;
                        t_blink_cnt = '0;
                        t_dirty     = 1'b1;
                    end
                    else
                        t_blink_cnt = el;
                end
            end
            EV_PRESS:
            begin
                case (t_mode)
                    MODE_IDLE:
                    begin
                        t_mode   = MODE_SET;
                        t_field  = FIELD_HOURS;
                        t_edit_h = t_saved_h;
                        t_edit_m = t_saved_m;
                        t_edit_s = t_saved_s;
                        rearm_blink();
                    end
                    MODE_SET:
                    begin
                        if (t_field != FIELD_SECONDS)
                        begin
                            t_field = field_t'(t_field + 2'd1);
                            rearm_blink();
                        end
                        else
                        begin
                            total = (t_edit_h * 3600 + t_edit_m * 60 + t_edit_s) * 1000;
                            if (total == 0)
                            begin
                                bp      = BEEP_DOUBLE;
                                t_field = FIELD_HOURS;
                                t_dirty = 1'b1;
                            end
                            else
                            begin
                                t_saved_h = t_edit_h;
                                t_saved_m = t_edit_m;
                                t_saved_s = t_edit_s;
                                t_rem     = total;
                                t_seen    = 8'd255;
                                t_mode    = MODE_RUN;
                                bp        = BEEP_SHORT;
                                t_dirty   = 1'b1;
                            end
                        end
                    end
                    MODE_RUN:
                    begin
                        t_mode  = MODE_PAUSE;
                        t_dirty = 1'b1;
                    end
                    MODE_PAUSE:
                    begin
                        t_mode  = MODE_RUN;
                        bp      = BEEP_SHORT;
                        t_dirty = 1'b1;
                    end
                    MODE_FIN:
                    begin
                        t_mode  = MODE_IDLE;
                        bp      = BEEP_STOP;
                        t_dirty = 1'b1;
                    end
                    default: ;
                endcase
            end
            EV_LONG:
            begin
                if (t_mode == MODE_RUN || t_mode == MODE_PAUSE || t_mode == MODE_SET)
                begin
                    t_mode  = MODE_IDLE;
                    t_rem   = 0;
                    t_dirty = 1'b1;
                    bp      = BEEP_SHORT;
                end
            end
            EV_SCROLL_UP, EV_SCROLL_DN:
            begin
                if (t_mode == MODE_SET)
                begin
                    case (t_field)
                        FIELD_HOURS:   t_edit_h = 7'(roll(t_edit_h, MAX_HOURS, up));
                        FIELD_MINUTES: t_edit_m = 6'(roll(t_edit_m, MAX_MINSEC, up));
                        FIELD_SECONDS: t_edit_s = 6'(roll(t_edit_s, MAX_MINSEC, up));
                        default: ;
                    endcase
                    rearm_blink();
                end
            end
            default: ;   // spare codes: no state change, result still owed
        endcase

        r.mode       = t_mode;
        r.edit_field = t_field;
        if (t_mode == MODE_IDLE)
        begin
            r.show_hours   = t_saved_h;
            r.show_minutes = t_saved_m;
            r.show_seconds = t_saved_s;
        end
        else if (t_mode == MODE_SET)
        begin
            r.show_hours   = t_edit_h;
            r.show_minutes = t_edit_m;
            r.show_seconds = t_edit_s;
        end
        else
        begin
            secs           = (t_rem + 999) / 1000;   // partial second shows as whole
            r.show_hours   = 7'((secs / 3600) % 100);
            r.show_minutes = 6'((secs / 60) % 60);
            r.show_seconds = 6'(secs % 60);
        end
        r.blink_on = t_blink_ph;
        r.flash_on = t_flash_ph;
        r.redraw   = t_dirty;
        r.beep     = bp;
        t_dirty    = 1'b0;   // redraw is one-shot
        return r;
    endfunction

    // Hand-written expectation for the opening table
    function automatic res_t shown(mode_t md, field_t fd, int h, int m, int s,
                                   bit bl, bit fl, bit rd, beep_t bp);
        res_t r;
        r.mode         = md;
        r.edit_field   = fd;
        r.show_hours   = 7'(h);
        r.show_minutes = 6'(m);
        r.show_seconds = 6'(s);
        r.blink_on     = bl;
        r.flash_on     = fl;
        r.redraw       = rd;
        r.beep         = bp;
        return r;
    endfunction

    // Mostly back to back, sometimes a few cycles, rarely a long gap
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic rnd_busy();
        return 1'($urandom_range(0, 1));
    endfunction

    // ------------------------------------------------------------------
    // Sender: holds the item until taken, then logs what the block owes
    // ------------------------------------------------------------------
    task automatic offer_row(input logic [2:0] kind, input logic busy,
                             input logic known, input res_t want);
        evt_t ev;
        res_t predicted;
        int   gap;
        ev.kind        = kind;
        ev.buzzer_busy = busy;
        in_item  <= ev;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        predicted = timer_next(ev);
        due_displays.push_back(known ? want : predicted);
        items_sent++;
        gap = send_steady ? 0 : pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic offer_item(input logic [2:0] kind, input logic busy);
        offer_row(kind, busy, 1'b0, '0);
    endtask

    task automatic add_row(input logic [2:0] kind, input logic busy,
                           input logic known, input res_t want);
        step_row_t row;
        row.kind  = kind;
        row.busy  = busy;
        row.known = known;
        row.want  = want;
        opening_steps.push_back(row);
    endtask

    // Drop valid and let every owed result drain
    task automatic settle();
        in_valid <= 1'b0;
        while (due_displays.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_BLINK: blink_per = val;
            CFG_FLASH: flash_per = val;
            CFG_ALARM: alarm_per = val;
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Sequence builders, steered by the model state
    // ------------------------------------------------------------------

    // Get to setting mode with the hours field selected
    task automatic go_setting();
        if (t_mode == MODE_RUN || t_mode == MODE_PAUSE)
            offer_item(EV_LONG, rnd_busy());
        if (t_mode == MODE_FIN)
            offer_item(EV_PRESS, rnd_busy());
        if (t_mode == MODE_SET && t_field != FIELD_HOURS)
            offer_item(EV_LONG, rnd_busy());
        if (t_mode == MODE_IDLE)
            offer_item(EV_PRESS, rnd_busy());
    endtask

    // Scroll each field to its target the short way round, press after each.
    // The last press starts the run, or double-beeps on an all-zero time.
    task automatic dial_to(input int unsigned h, input int unsigned m, input int unsigned s);
        int unsigned target, cur, span, du;
        for (int f = 0; f < 3; f++)
        begin
            target = (f == 0) ? h : (f == 1) ? m : s;
            span   = (f == 0) ? int'(MAX_HOURS) + 1 : int'(MAX_MINSEC) + 1;
            cur    = (f == 0) ? t_edit_h : (f == 1) ? t_edit_m : t_edit_s;
            while (cur != target)
            begin
                du = (target + span - cur) % span;
                offer_item((du <= span / 2) ? EV_SCROLL_UP : EV_SCROLL_DN, rnd_busy());
                if ($urandom_range(0, 9) == 0)
                    offer_item(EV_TICK, rnd_busy());
                cur = (f == 0) ? t_edit_h : (f == 1) ? t_edit_m : t_edit_s;
            end
            offer_item(EV_PRESS, rnd_busy());
        end
    endtask

    // One-second run to expiry, with the odd pause, then a stretch of
    // flashing and alarm repeats on the current periods, another on short
    // flash and alarm periods, both with a randomly busy buzzer, then stop.
    task automatic run_to_alarm();
        int n;
        int r;
        go_setting();
        dial_to(0, 0, 1);
        while (t_mode == MODE_RUN || t_mode == MODE_PAUSE)
        begin
            if (t_mode == MODE_PAUSE)
                offer_item(($urandom_range(0, 3) == 0) ? EV_PRESS : EV_TICK, rnd_busy());
            else
                offer_item(($urandom_range(0, 399) == 0) ? EV_PRESS : EV_TICK, rnd_busy());
        end
        for (int k = 0; k < 2; k++)
        begin
            if (k == 1)
            begin
                // still finished: counted flash toggles and alarm repeats
                write_reg(CFG_FLASH, 12'($urandom_range(1, 25)));
                write_reg(CFG_ALARM, 12'($urandom_range(1, 25)));
            end
            n = $urandom_range(25, 60);
            repeat (n)
            begin
                r = $urandom_range(0, 9);
                if (r < 8)
                    offer_item(EV_TICK, rnd_busy());
                else if (r == 8)
                    offer_item($urandom_range(0, 1) ? EV_SCROLL_UP : EV_SCROLL_DN,
                               rnd_busy());
                else
                    offer_item(EV_LONG, rnd_busy());   // no effect once finished
            end
        end
        offer_item(EV_PRESS, rnd_busy());
    endtask

    // Random time, short stretch of run/pause activity, then abandon
    task automatic short_run();
        int unsigned h;
        int          r;
        go_setting();
        r = $urandom_range(0, 3);
        h = (r == 0) ? 0 : (r == 1) ? int'(MAX_HOURS) : (r == 2) ? 1 : $urandom_range(0, 99);
        dial_to(h, $urandom_range(0, 59), $urandom_range(0, 59));
        repeat ($urandom_range(5, 40))
        begin
            r = $urandom_range(0, 9);
            if (r < 7)
                offer_item(EV_TICK, rnd_busy());
            else if (r < 9)
                offer_item(EV_PRESS, rnd_busy());
            else
                offer_item($urandom_range(0, 1) ? EV_SCROLL_UP : EV_SCROLL_DN, rnd_busy());
        end
        offer_item(EV_LONG, rnd_busy());
    endtask

    // Idle time in setting mode: blink ticks mixed with edits
    task automatic set_wander(input bit zero_first);
        int r;
        go_setting();
        if (zero_first)
            dial_to(0, 0, 0);
        repeat ($urandom_range(8, 50))
        begin
            r = $urandom_range(0, 9);
            if (r < 5)
                offer_item(EV_TICK, rnd_busy());
            else if (r < 7)
                offer_item(EV_SCROLL_UP, rnd_busy());
            else if (r < 9)
                offer_item(EV_SCROLL_DN, rnd_busy());
            else
                offer_item(EV_PRESS, rnd_busy());
        end
    endtask

    task automatic random_phase(input bit with_alarm);
        int start;
        int pick;
        if (with_alarm)
            run_to_alarm();
        start = items_sent;
        while (items_sent - start < PHASE_ITEMS)
        begin
            send_steady = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 9);
            if (pick < 4)
                short_run();
            else if (pick < 6)
                set_wander(1'b1);
            else if (pick < 8)
                set_wander(1'b0);
            else
                repeat ($urandom_range(4, 16))
                    offer_item(3'($urandom_range(EV_TICK, EV_SPARE_HI)), rnd_busy());
        end
        send_steady = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    function void note_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            displays_seen++;
            if (due_displays.size() == 0)
            begin
                $display("%0t: result with nothing owed, expected none, got %h",
                         $time, out_item);
                errors++;
            end
            else
            begin
                want = due_displays.pop_front();
                note_field("mode",         want.mode,         out_item.mode);
                note_field("edit_field",   want.edit_field,   out_item.edit_field);
                note_field("show_hours",   want.show_hours,   out_item.show_hours);
                note_field("show_minutes", want.show_minutes, out_item.show_minutes);
                note_field("show_seconds", want.show_seconds, out_item.show_seconds);
                note_field("blink_on",     want.blink_on,     out_item.blink_on);
                note_field("flash_on",     want.flash_on,     out_item.flash_on);
                note_field("redraw",       want.redraw,       out_item.redraw);
                note_field("beep",         want.beep,         out_item.beep);
            end
        end
    end

    // Hang guard
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, steady stretches, and one long hold-off
    // while the sender keeps going so the block backs up into in_stall
    // ------------------------------------------------------------------
    initial
    begin
        bit held;
        held = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 199) == 0)
                recv_steady = ~recv_steady;
            if (!held && displays_seen >= 400)
            begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (!recv_steady && $urandom_range(0, 99) < 25)
            begin
                out_stall <= 1'b1;
                repeat (pick_gap() + 1) @(posedge clk);
                out_stall <= 1'b0;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_item     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        items_sent  = 0;
        send_steady = 1'b0;

        // model at reset
        blink_per    = CFG_RESET.blink_period;
        flash_per    = CFG_RESET.flash_period;
        alarm_per    = CFG_RESET.alarm_repeat;
        t_mode       = MODE_IDLE;
        t_field      = FIELD_HOURS;
        t_saved_h    = 7'd0;
        t_saved_m    = 6'd5;
        t_saved_s    = 6'd0;
        t_edit_h     = 7'd0;
        t_edit_m     = 6'd5;
        t_edit_s     = 6'd0;
        t_rem        = 0;
        t_seen       = 8'd255;
        t_dirty      = 1'b1;
        t_blink_ph   = 1'b1;
        t_flash_ph   = 1'b1;
        t_alarm_done = 1'b0;
        t_blink_cnt  = '0;
        t_flash_cnt  = '0;
        t_alarm_cnt  = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Opening table, reset config. Idle: ignored events and spare codes
        // still report; redraw only on the first result after reset.
        add_row(EV_TICK, 1'b0, 1'b1,
                shown(MODE_IDLE, FIELD_HOURS, 0, 5, 0, 1, 1, 1, BEEP_NONE));
        add_row(EV_SPARE_LO, 1'b1, 1'b1,
                shown(MODE_IDLE, FIELD_HOURS, 0, 5, 0, 1, 1, 0, BEEP_NONE));
        add_row(EV_SPARE_HI, 1'b0, 1'b1,
                shown(MODE_IDLE, FIELD_HOURS, 0, 5, 0, 1, 1, 0, BEEP_NONE));
        add_row(EV_LONG, 1'b1, 1'b1,
                shown(MODE_IDLE, FIELD_HOURS, 0, 5, 0, 1, 1, 0, BEEP_NONE));
        add_row(EV_SCROLL_UP, 1'b0, 1'b1,
                shown(MODE_IDLE, FIELD_HOURS, 0, 5, 0, 1, 1, 0, BEEP_NONE));
        // setting: hours wrap both ways at the top value
        add_row(EV_PRESS, 1'b0, 1'b1,
                shown(MODE_SET, FIELD_HOURS, 0, 5, 0, 1, 1, 1, BEEP_NONE));
        add_row(EV_SCROLL_DN, 1'b1, 1'b1,
                shown(MODE_SET, FIELD_HOURS, 99, 5, 0, 1, 1, 1, BEEP_NONE));
        add_row(EV_SCROLL_UP, 1'b0, 1'b1,
                shown(MODE_SET, FIELD_HOURS, 0, 5, 0, 1, 1, 1, BEEP_NONE));
        add_row(EV_SCROLL_DN, 1'b0, 1'b1,
                shown(MODE_SET, FIELD_HOURS, 99, 5, 0, 1, 1, 1, BEEP_NONE));
        add_row(EV_PRESS, 1'b0, 1'b1,
                shown(MODE_SET, FIELD_MINUTES, 99, 5, 0, 1, 1, 1, BEEP_NONE));
        add_row(EV_SCROLL_UP, 1'b1, 1'b0, '0);
        add_row(EV_PRESS, 1'b0, 1'b0, '0);
        // seconds wrap both ways
        add_row(EV_SCROLL_DN, 1'b0, 1'b1,
                shown(MODE_SET, FIELD_SECONDS, 99, 6, 59, 1, 1, 1, BEEP_NONE));
        add_row(EV_SCROLL_UP, 1'b0, 1'b1,
                shown(MODE_SET, FIELD_SECONDS, 99, 6, 0, 1, 1, 1, BEEP_NONE));
        add_row(EV_SCROLL_DN, 1'b1, 1'b1,
                shown(MODE_SET, FIELD_SECONDS, 99, 6, 59, 1, 1, 1, BEEP_NONE));
        add_row(EV_TICK, 1'b0, 1'b0, '0);
        // start at near-max time, pause, resume, abandon
        add_row(EV_PRESS, 1'b0, 1'b1,
                shown(MODE_RUN, FIELD_SECONDS, 99, 6, 59, 1, 1, 1, BEEP_SHORT));
        add_row(EV_TICK, 1'b1, 1'b0, '0);
        add_row(EV_TICK, 1'b0, 1'b0, '0);
        add_row(EV_PRESS, 1'b0, 1'b0, '0);
        add_row(EV_TICK, 1'b0, 1'b0, '0);
        add_row(EV_PRESS, 1'b1, 1'b0, '0);
        add_row(EV_LONG, 1'b0, 1'b1,
                shown(MODE_IDLE, FIELD_SECONDS, 99, 6, 59, 1, 1, 1, BEEP_SHORT));
        add_row(EV_LONG, 1'b0, 1'b1,
                shown(MODE_IDLE, FIELD_SECONDS, 99, 6, 59, 1, 1, 0, BEEP_NONE));

        foreach (opening_steps[i])
            offer_row(opening_steps[i].kind, opening_steps[i].busy,
                      opening_steps[i].known, opening_steps[i].want);

        // Zero periods: every phase toggles each tick, alarm due every tick;
        // the alarm stretch then moves on to short flash and alarm periods
        write_reg(CFG_BLINK, 12'd0);
        write_reg(CFG_FLASH, 12'd0);
        write_reg(CFG_ALARM, 12'd0);
        random_phase(1'b1);

        // Longest periods, plus a write to the unused index
        write_reg(CFG_BLINK, 12'd4095);
        write_reg(CFG_FLASH, 12'd4095);
        write_reg(CFG_ALARM, 12'd4095);
        write_reg(CFG_SPARE, 12'($urandom_range(0, 4095)));
        random_phase(1'b0);

        // Short random periods so blink toggles show up often
        write_reg(CFG_BLINK, 12'($urandom_range(1, 25)));
        write_reg(CFG_FLASH, 12'($urandom_range(1, 25)));
        write_reg(CFG_ALARM, 12'($urandom_range(1, 25)));
        random_phase(1'b0);

        // Mixed: blink period of 1, long flash, short alarm
        write_reg(CFG_BLINK, 12'd1);
        write_reg(CFG_FLASH, 12'($urandom_range(1000, 4095)));
        write_reg(CFG_ALARM, 12'd2);
        random_phase(1'b0);

        settle();
        repeat (5) @(posedge clk);
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
